FILE: hdl/efcp_pkg.sv
// Types, constants and sine table builder for the fly camera pose block.
package efcp_pkg;

   localparam int ONE_Q14 = 16384;

   typedef struct packed {
      logic signed [15:0] mouse_dx;
      logic signed [15:0] mouse_dy;
      logic [5:0]         key_mask;
      logic [15:0]        frame_time;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] look_x;
      logic signed [31:0] look_y;
      logic signed [31:0] look_z;
      logic signed [15:0] up_x;
      logic signed [15:0] up_y;
      logic signed [15:0] up_z;
   } rsp_type;

   typedef enum logic [1:0] {
      CSR_ROLL  = 2'd0,
      CSR_GAIN  = 2'd1,
      CSR_SPEED = 2'd2
   } csr_index_type;

   // Sequencer states: angle update, move accumulation, trig fetch,
   // vector products, result hold.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ANGLE,
      ST_MOVE,
      ST_TRIG,
      ST_VEC,
      ST_DONE
   } state_type;

   // One quarter-wave entry in Q1.14 from a seven-term Q30 Taylor series.
   function automatic logic [14:0] sine_entry(input int i, input int depth);
      logic [63:0] x, s, term;
      logic [63:0] q;
      x = (64'd1686629713 * 64'(i)) / 64'(depth);
      s = x;
      term = x;
      for (int k = 1; k <= 6; k++) begin
         term = (((term * x) >> 30) * x) >> 30;
         term = term / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) s = s - term;
         else s = s + term;
      end
      q = (s + 64'd32768) >> 16;
      if (q > 64'(ONE_Q14)) q = 64'(ONE_Q14);
      return q[14:0];
   endfunction

endpackage

FILE: hdl/efcp_mul.sv
// Bit-serial signed multiplier: 34-bit signed multiplicand by 34-bit signed
// multiplier, one multiplier bit per cycle.
module efcp_mul
   import efcp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [33:0] op_a,
   input  logic signed [33:0] op_b,
   output logic               done,
   output logic signed [67:0] product
);
   logic [5:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic signed [67:0] acc_ff, acc_in;
   logic signed [67:0] mcand_ff, mcand_in;
   logic [33:0]        mplier_ff, mplier_in;
   logic               done_ff, done_in;

   always_comb begin
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      done_in   = 1'b0;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         acc_in    = '0;
         mcand_in  = 68'(op_a);
         mplier_in = op_b;
      end else if (busy_ff) begin
         // The top multiplier bit carries negative weight.
         if (mplier_ff[0]) begin
            if (cnt_ff == 6'd33) acc_in = acc_ff - mcand_ff;
            else acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = mcand_ff <<< 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + 6'd1;
         if (cnt_ff == 6'd33) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule

FILE: hdl/euler_fly_camera_pose.sv
// Top level of the Euler-angle fly camera pose block.
//
//  Channel | Ports                          | Direction | Content
//  req     | req_valid, req_stall, req_data | in        | mouse delta, keys, frame time
//  rsp     | rsp_valid, rsp_stall, rsp_data | out       | position, lookat, up vector
//  csr     | csr_we, csr_index, csr_wdata   | in        | roll, look gain, move speed
//
// One item at a time. A single bit-serial multiplier is shared by all products,
// and an item needs 27 products plus a trig fetch and a result load before the
// result appears. The next request can be taken once the sequencer has loaded the
// result and returned to idle.
// Reset is synchronous and restores the initial pose and register values.
// The result holds in an output register; a new request is taken while it
// waits, and the next result waits until the previous one is transferred.
module euler_fly_camera_pose
   import efcp_pkg::*;
#(
   parameter int ANGLE_BITS       = 16,
   parameter int SINE_TABLE_DEPTH = 256
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   localparam int PB = ANGLE_BITS - 2;
   localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int DB = $clog2(SINE_TABLE_DEPTH);

   // Micro-op codes of the product sequence.
   localparam logic [4:0] OP_DYAW = 5'd0, OP_DPITCH = 5'd1, OP_SCALE = 5'd2;

   function automatic logic [14:0] tab(input logic [IW-1:0] i);
      logic [14:0] r;
      r = '0;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++)
         if (i == IW'(k)) r = sine_entry(k, SINE_TABLE_DEPTH);
      return r;
   endfunction

   function automatic logic signed [15:0] sine_of(input logic [ANGLE_BITS-1:0] a);
      logic [1:0]    quad;
      logic [IW-1:0] idx, sel;
      logic [15:0]   v;
      quad = a[ANGLE_BITS-1 -: 2];
      idx  = IW'((PB + DB)'(a[PB-1:0]) * (PB + DB)'(SINE_TABLE_DEPTH) >> PB);
      sel  = quad[0] ? IW'(SINE_TABLE_DEPTH) - idx : idx;
      v    = {1'b0, tab(sel)};
      return quad[1] ? -v : v;
   endfunction

   function automatic logic signed [33:0] rnd14(input logic signed [67:0] p);
      logic signed [67:0] t;
      t = (p + 68'sd8192) >>> 14;
      return t[33:0];
   endfunction

   function automatic logic signed [15:0] clampu(input logic signed [33:0] v);
      if (v > 34'sd16384) return 16'sd16384;
      if (v < -34'sd16384) return -16'sd16384;
      return v[15:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      if (v > 36'sh07FFFFFFF) return 32'h7FFFFFFF;
      if (v < -36'sh080000000) return 32'h80000000;
      return v[31:0];
   endfunction

   state_type state_ff, state_in;

   logic [15:0] roll_ff, gain_ff, speed_ff;
   logic [ANGLE_BITS-1:0] yaw_ff, pitch_ff, yaw_in, pitch_in;
   logic signed [31:0] pos_ff [3];
   logic signed [15:0] fwd_ff [3], up_ff [3], rgt_ff [3];
   logic signed [35:0] acc_ff [3];
   req_type req_ff;
   logic [4:0] step_ff, step_in;
   logic signed [33:0] scal_ff, tmp_ff;
   logic signed [15:0] sy_ff, cy_ff, sp_ff, cp_ff, sr_ff, cr_ff;
   logic signed [15:0] f_ff [3], u_ff [3];
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   logic mul_start, mul_done, mul_issued_ff;
   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] mul_p;

   efcp_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   logic [ANGLE_BITS-1:0] roll_ang, quarter;
   assign quarter = ANGLE_BITS'(1) << PB;

   // The roll register is a 16-bit binary angle; scale it to the angle width.
   generate
      if (ANGLE_BITS >= 16) begin : g_roll_wide
         assign roll_ang = ANGLE_BITS'(roll_ff) << (ANGLE_BITS - 16);
      end else begin : g_roll_narrow
         assign roll_ang = ANGLE_BITS'(roll_ff >> (16 - ANGLE_BITS));
      end
   endgenerate

   // Operand selection for each product step.
   logic [1:0] axis;
   logic [1:0] vsel;
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      axis  = '0;
      vsel  = '0;
      if (state_ff == ST_ANGLE) begin
         mul_a = 34'(req_ff.mouse_dx);
         if (step_ff == OP_DPITCH) mul_a = 34'(req_ff.mouse_dy);
         mul_b = 34'(gain_ff);
         if (step_ff == OP_SCALE) begin
            mul_a = 34'(speed_ff);
            mul_b = 34'(req_ff.frame_time);
         end
      end else if (state_ff == ST_MOVE) begin
         // Steps run axis by axis: forward, right, up for each.
         if (step_ff inside {[5'd3:5'd5]}) axis = 2'd1;
         else if (step_ff inside {[5'd6:5'd8]}) axis = 2'd2;
         if (step_ff inside {5'd1, 5'd4, 5'd7}) vsel = 2'd1;
         else if (step_ff inside {5'd2, 5'd5, 5'd8}) vsel = 2'd2;
         mul_b = scal_ff;
         case (vsel)
            2'd0:    mul_a = 34'(fwd_ff[axis]);
            2'd1:    mul_a = 34'(rgt_ff[axis]);
            default: mul_a = 34'(up_ff[axis]);
         endcase
      end else if (state_ff == ST_VEC) begin
         case (step_ff)
            5'd0:    begin mul_a = 34'(sy_ff); mul_b = 34'(cp_ff); end
            5'd1:    begin mul_a = 34'(cp_ff); mul_b = 34'(cy_ff); end
            5'd2:    begin mul_a = 34'(sy_ff); mul_b = 34'(sp_ff); end
            5'd3:    begin mul_a = 34'(cy_ff); mul_b = 34'(sr_ff); end
            5'd4:    begin mul_a = tmp_ff;     mul_b = 34'(cr_ff); end
            5'd5:    begin mul_a = 34'(cp_ff); mul_b = 34'(cr_ff); end
            5'd6:    begin mul_a = 34'(sp_ff); mul_b = 34'(cr_ff); end
            5'd7:    begin mul_a = 34'(sy_ff); mul_b = 34'(sr_ff); end
            5'd8:    begin mul_a = tmp_ff;     mul_b = 34'(cy_ff); end
            5'd9:    begin mul_a = 34'(f_ff[1]); mul_b = 34'(u_ff[2]); end
            5'd10:   begin mul_a = 34'(f_ff[2]); mul_b = 34'(u_ff[1]); end
            5'd11:   begin mul_a = 34'(f_ff[2]); mul_b = 34'(u_ff[0]); end
            5'd12:   begin mul_a = 34'(f_ff[0]); mul_b = 34'(u_ff[2]); end
            5'd13:   begin mul_a = 34'(f_ff[0]); mul_b = 34'(u_ff[1]); end
            default: begin mul_a = 34'(f_ff[1]); mul_b = 34'(u_ff[0]); end
         endcase
      end
   end

   localparam logic [4:0] MOVE_LAST = 5'd8, VEC_LAST = 5'd14;

   // Next state.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) begin state_in = ST_ANGLE; step_in = '0; end
         ST_ANGLE: if (mul_done) begin
            step_in = step_ff + 5'd1;
            if (step_ff == OP_SCALE) begin state_in = ST_MOVE; step_in = '0; end
         end
         ST_MOVE: if (mul_done) begin
            step_in = step_ff + 5'd1;
            if (step_ff == MOVE_LAST) begin state_in = ST_TRIG; step_in = '0; end
         end
         ST_TRIG: state_in = ST_VEC;
         ST_VEC: if (mul_done) begin
            step_in = step_ff + 5'd1;
            if (step_ff == VEC_LAST) state_in = ST_DONE;
         end
         ST_DONE: if (!rsp_valid_ff) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      mul_start = !mul_issued_ff &&
                  (state_ff == ST_ANGLE || state_ff == ST_MOVE || state_ff == ST_VEC);
   end

   logic signed [33:0] r_p;
   logic signed [35:0] d_p;
   logic [5:0] keys;
   assign r_p  = rnd14(mul_p);
   assign d_p  = 36'(mul_p >>> 22);
   assign keys = req_ff.key_mask;

   always_comb begin
      yaw_in   = yaw_ff   - ANGLE_BITS'(mul_p >>> 8);
      pitch_in = pitch_ff - ANGLE_BITS'(mul_p >>> 8);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         mul_issued_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         roll_ff  <= 16'd0;
         gain_ff  <= 16'd2330;
         speed_ff <= 16'd1280;
         yaw_ff   <= '0;
         pitch_ff <= '0;
         for (int j = 0; j < 3; j++) pos_ff[j] <= '0;
         fwd_ff[0] <= '0; fwd_ff[1] <= '0; fwd_ff[2] <= -16'sd16384;
         up_ff[0]  <= '0; up_ff[1]  <= 16'sd16384; up_ff[2] <= '0;
         rgt_ff[0] <= 16'sd16384; rgt_ff[1] <= '0; rgt_ff[2] <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (mul_start) mul_issued_ff <= 1'b1;
         else if (mul_done) mul_issued_ff <= 1'b0;
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               CSR_ROLL:  roll_ff  <= csr_wdata;
               CSR_GAIN:  gain_ff  <= csr_wdata;
               CSR_SPEED: speed_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (state_ff == ST_IDLE && req_valid) begin
            req_ff <= req_data;
            for (int j = 0; j < 3; j++) acc_ff[j] <= 36'(pos_ff[j]);
         end
         if (state_ff == ST_ANGLE && mul_done) begin
            if (step_ff == OP_DYAW) yaw_ff <= yaw_in;
            else if (step_ff == OP_DPITCH) pitch_ff <= pitch_in;
            else scal_ff <= mul_p[33:0];
         end
         if (state_ff == ST_MOVE && mul_done) begin
            case (vsel)
               2'd0: begin
                  if (keys[0] && !keys[1]) acc_ff[axis] <= acc_ff[axis] + d_p;
                  if (keys[1] && !keys[0]) acc_ff[axis] <= acc_ff[axis] - d_p;
               end
               2'd1: begin
                  if (keys[3] && !keys[2]) acc_ff[axis] <= acc_ff[axis] + d_p;
                  if (keys[2] && !keys[3]) acc_ff[axis] <= acc_ff[axis] - d_p;
               end
               default: begin
                  if (keys[4] && !keys[5]) acc_ff[axis] <= acc_ff[axis] + d_p;
                  if (keys[5] && !keys[4]) acc_ff[axis] <= acc_ff[axis] - d_p;
               end
            endcase
         end
         if (state_ff == ST_TRIG) begin
            for (int j = 0; j < 3; j++) pos_ff[j] <= sat32(acc_ff[j]);
            sy_ff <= sine_of(yaw_ff);   cy_ff <= sine_of(yaw_ff + quarter);
            sp_ff <= sine_of(pitch_ff); cp_ff <= sine_of(pitch_ff + quarter);
            sr_ff <= sine_of(roll_ang); cr_ff <= sine_of(roll_ang + quarter);
            f_ff[1] <= sine_of(pitch_ff);
         end
         if (state_ff == ST_VEC && mul_done) begin
            // The first product of up_x and of up_z waits in acc_ff[0],
            // since tmp_ff still holds the rounded pair for the next step.
            case (step_ff)
               5'd0:  f_ff[0] <= r_p[15:0];
               5'd1:  f_ff[2] <= 16'(rnd14(-mul_p));
               5'd2:  tmp_ff <= r_p;
               5'd3:  acc_ff[0] <= 36'(-mul_p);
               5'd4:  u_ff[0] <= clampu(rnd14(68'(acc_ff[0]) - mul_p));
               5'd5:  u_ff[1] <= clampu(r_p);
               5'd6:  tmp_ff <= r_p;
               5'd7:  acc_ff[0] <= 36'(-mul_p);
               5'd8:  u_ff[2] <= clampu(rnd14(68'(acc_ff[0]) + mul_p));
               5'd9, 5'd11, 5'd13: tmp_ff <= mul_p[33:0];
               5'd10: rgt_ff[0] <= clampu(rnd14(68'(tmp_ff) - mul_p));
               5'd12: rgt_ff[1] <= clampu(rnd14(68'(tmp_ff) - mul_p));
               default: rgt_ff[2] <= clampu(rnd14(68'(tmp_ff) - mul_p));
            endcase
         end
         if (state_ff == ST_DONE && !rsp_valid_ff) begin
            rsp_valid_ff <= 1'b1;
            for (int j = 0; j < 3; j++) begin
               fwd_ff[j] <= f_ff[j];
               up_ff[j]  <= u_ff[j];
            end
            rsp_ff.pos_x  <= pos_ff[0];
            rsp_ff.pos_y  <= pos_ff[1];
            rsp_ff.pos_z  <= pos_ff[2];
            rsp_ff.look_x <= sat32(36'(pos_ff[0]) + 36'(f_ff[0]) * 36'sd4);
            rsp_ff.look_y <= sat32(36'(pos_ff[1]) + 36'(f_ff[1]) * 36'sd4);
            rsp_ff.look_z <= sat32(36'(pos_ff[2]) + 36'(f_ff[2]) * 36'sd4);
            rsp_ff.up_x   <= u_ff[0];
            rsp_ff.up_y   <= u_ff[1];
            rsp_ff.up_z   <= u_ff[2];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_one_mul: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_issued_ff) else $error("multiplier restarted while busy");
   a_idle_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == ST_ANGLE) else $error("request not taken");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("result dropped");
endmodule
